>>> hw/rtl/fcct_pkg.sv
// ---------------------------------------------------------------------------
// fcct_pkg
// Shared types and codes of the frame change capture table.
// ---------------------------------------------------------------------------
package fcct_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_CSUM_HIGH  = 2'd0;
    localparam logic [1:0] CFG_CSUM_LOW   = 2'd1;
    localparam logic [1:0] CFG_CSUM_EXTRA = 2'd2;
    localparam logic [1:0] CFG_LONG_LEN   = 2'd3;

    localparam logic [5:0] CSUM_HIGH_RST  = 6'd18;
    localparam logic [5:0] CSUM_LOW_RST   = 6'd19;
    localparam logic [5:0] CSUM_EXTRA_RST = 6'd32;
    localparam logic [6:0] LONG_LEN_RST   = 7'd33;

    // record types
    localparam logic REC_CHANGE  = 1'b0;
    localparam logic REC_SUMMARY = 1'b1;

    // summary dispositions
    localparam logic [1:0] DISP_NONE      = 2'd0;
    localparam logic [1:0] DISP_BASELINE  = 2'd1;
    localparam logic [1:0] DISP_UNCHANGED = 2'd2;
    localparam logic [1:0] DISP_CHANGED   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_BRD,
        ST_BCMP,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic       record_type;
        logic [5:0] byte_index;
        logic [7:0] before_value;
        logic [7:0] after_value;
        logic [7:0] change_mask;
        logic [1:0] disposition;
        logic [6:0] change_total;
        logic [6:0] frame_length;
        logic       last_record;
    } out_rec_t;

endpackage

>>> hw/rtl/frame_change_capture_table_core.sv
// ---------------------------------------------------------------------------
// frame_change_capture_table_core
// Stages a frame, finds its slot and reports byte changes against it.
// ---------------------------------------------------------------------------
// Bytes are taken one a cycle while the block is idle. On the last byte the
// block scans the slot table through the metadata ram, one slot a cycle, and
// stops early on a hit, then walks the frame through the staging and slot
// byte rams, each byte passing a read state (ST_BRD) and a compare state
// (ST_BCMP), then issues the summary. The compare holds while a change record
// is due and the result side still holds the last one; the summary waits
// for the result side too. A changed frame takes a second walk that stores the
// whole frame, checksum bytes included. A rejected frame goes straight to the
// summary. No clearing pass is needed after reset: slot bytes are read only
// after being stored.
module frame_change_capture_table_core #(
    parameter int NUM_SLOTS       = 16,
    parameter int MAX_FRAME_BYTES = 33,
    parameter int MAX_REPORTED    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // frame_byte, operation key, sequence_req
    input  logic        s_tlast,
    input  logic [8:0]  s_tuser,   // frame_valid, kind_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // byte_index, before_value, after_value,
                                   // change_mask, change count, frame_length
    output logic        m_tlast,
    output logic [2:0]  m_tuser,   // record_type, disposition
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_wdata
);

    localparam int SW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IW   = $clog2(MAX_FRAME_BYTES);
    localparam int BD   = NUM_SLOTS * MAX_FRAME_BYTES;
    localparam int BAW  = $clog2(BD);
    localparam int MW   = 8 + 16 + 7 + 32;
    localparam logic [6:0] MAX_LEN = 7'(MAX_FRAME_BYTES);

    // configuration
    logic [5:0] csum_high_reg, csum_low_reg, csum_extra_reg;
    logic [6:0] long_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            csum_high_reg  <= fcct_pkg::CSUM_HIGH_RST;
            csum_low_reg   <= fcct_pkg::CSUM_LOW_RST;
            csum_extra_reg <= fcct_pkg::CSUM_EXTRA_RST;
            long_len_reg   <= fcct_pkg::LONG_LEN_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                fcct_pkg::CFG_CSUM_HIGH:  csum_high_reg  <= cfg_wdata[5:0];
                fcct_pkg::CFG_CSUM_LOW:   csum_low_reg   <= cfg_wdata[5:0];
                fcct_pkg::CFG_CSUM_EXTRA: csum_extra_reg <= cfg_wdata[5:0];
                fcct_pkg::CFG_LONG_LEN:   long_len_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input fields
    logic [7:0]  in_byte;
    logic [15:0] in_key;
    logic [31:0] in_seq;
    logic        in_valid;
    logic [7:0]  in_kind;
    assign in_byte  = s_tdata[7:0];
    assign in_key   = s_tdata[23:8];
    assign in_seq   = s_tdata[55:24];
    assign in_valid = s_tuser[0];
    assign in_kind  = s_tuser[8:1];

    fcct_pkg::state_t state_reg, state_next;

    logic [6:0]    count_reg, count_next;
    logic [6:0]    len_reg, len_next;
    logic [7:0]    kind_reg, kind_next;
    logic [15:0]   key_reg, key_next;
    logic [31:0]   seq_reg, seq_next;
    logic          none_reg, none_next;
    logic [SW:0]   cnt_reg, cnt_next;
    logic          free_found_reg, free_found_next;
    logic [SW-1:0] free_slot_reg, free_slot_next;
    logic          old_found_reg, old_found_next;
    logic [SW-1:0] old_slot_reg, old_slot_next;
    logic [31:0]   old_age_reg, old_age_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic          base_reg, base_next;
    logic          wb_reg, wb_next;
    logic [6:0]    i_reg, i_next;
    logic [4:0]    rep_reg, rep_next;
    logic [6:0]    total_reg, total_next;
    logic [NUM_SLOTS-1:0] used_reg, used_next;

    fcct_pkg::out_rec_t out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    // memories
    logic            stg_we;
    logic [IW-1:0]   stg_rd_addr;
    logic [7:0]      stg_rd;
    logic            meta_we;
    logic [MW-1:0]   meta_wdata, meta_rd;
    logic [SW-1:0]   meta_rd_addr;
    logic            byte_we;
    logic [BAW-1:0]  byte_addr;
    logic [7:0]      byte_rd;

    fcct_ram #(.WIDTH(8), .DEPTH(MAX_FRAME_BYTES), .AW(IW)) u_stage (
        .aclk    (aclk),
        .wr_en   (stg_we),
        .wr_addr (count_reg[IW-1:0]),
        .wr_data (in_byte),
        .rd_addr (stg_rd_addr),
        .rd_data (stg_rd)
    );

    fcct_ram #(.WIDTH(MW), .DEPTH(NUM_SLOTS), .AW(SW)) u_meta (
        .aclk    (aclk),
        .wr_en   (meta_we),
        .wr_addr (slot_reg),
        .wr_data (meta_wdata),
        .rd_addr (meta_rd_addr),
        .rd_data (meta_rd)
    );

    fcct_ram #(.WIDTH(8), .DEPTH(BD), .AW(BAW)) u_bytes (
        .aclk    (aclk),
        .wr_en   (byte_we),
        .wr_addr (byte_addr),
        .wr_data (stg_rd),
        .rd_addr (byte_addr),
        .rd_data (byte_rd)
    );

    assign byte_addr   = BAW'(32'(slot_reg) * 32'(MAX_FRAME_BYTES) + 32'(i_reg));
    assign stg_rd_addr = i_reg[IW-1:0];
    assign meta_wdata  = {kind_reg, key_reg, len_reg, seq_reg};

    logic s_acc, out_free;
    assign s_tready = (state_reg == fcct_pkg::ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign stg_we   = s_acc && (count_reg < MAX_LEN);

    // metadata fields of the slot checked this cycle
    logic [7:0]    md_kind;
    logic [15:0]   md_key;
    logic [6:0]    md_len;
    logic [31:0]   md_age;
    logic [SW-1:0] chk_slot;
    assign {md_kind, md_key, md_len, md_age} = meta_rd;
    assign chk_slot = SW'(cnt_reg - 1'b1);

    logic skip, differ;
    assign skip = (i_reg[5:0] == csum_high_reg) || (i_reg[5:0] == csum_low_reg)
                  || ((len_reg == long_len_reg) && (i_reg[5:0] == csum_extra_reg));
    assign differ = !base_reg && !skip && (stg_rd != byte_rd);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        len_next        = len_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        seq_next        = seq_reg;
        none_next       = none_reg;
        cnt_next        = cnt_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        old_found_next  = old_found_reg;
        old_slot_next   = old_slot_reg;
        old_age_next    = old_age_reg;
        slot_next       = slot_reg;
        base_next       = base_reg;
        wb_next         = wb_reg;
        i_next          = i_reg;
        rep_next        = rep_reg;
        total_next      = total_reg;
        used_next       = used_reg;
        out_next        = out_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        meta_we         = 1'b0;
        byte_we         = 1'b0;
        meta_rd_addr    = cnt_reg[SW-1:0];

        case (state_reg)
            fcct_pkg::ST_IDLE: begin
                if (s_acc) begin
                    count_next = (count_reg < MAX_LEN) ? count_reg + 7'd1 : MAX_LEN + 7'd1;
                    if (s_tlast) begin
                        len_next        = count_next;
                        count_next      = 7'd0;
                        kind_next       = in_kind;
                        key_next        = in_key;
                        seq_next        = in_seq;
                        none_next       = !in_valid || (len_next > MAX_LEN);
                        cnt_next        = '0;
                        free_found_next = 1'b0;
                        old_found_next  = 1'b0;
                        i_next          = 7'd0;
                        rep_next        = 5'd0;
                        total_next      = 7'd0;
                        base_next       = 1'b0;
                        wb_next         = 1'b0;
                        state_next      = none_next ? fcct_pkg::ST_SUM : fcct_pkg::ST_SRCH;
                    end
                end
            end
            fcct_pkg::ST_SRCH: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0) begin
                    if (used_reg[chk_slot] && md_kind == kind_reg && md_key == key_reg) begin
                        // hit: baseline when stored length is zero or differs
                        slot_next  = chk_slot;
                        base_next  = (md_len == 7'd0) || (md_len != len_reg);
                        state_next = fcct_pkg::ST_BRD;
                    end else begin
                        if (!used_reg[chk_slot] && !free_found_next) begin
                            free_found_next = 1'b1;
                            free_slot_next  = chk_slot;
                        end
                        if (used_reg[chk_slot] && (!old_found_reg || md_age < old_age_reg)) begin
                            old_found_next = 1'b1;
                            old_slot_next  = chk_slot;
                            old_age_next   = md_age;
                        end
                        if (cnt_reg == (SW+1)'(NUM_SLOTS)) begin
                            slot_next  = free_found_next ? free_slot_next : old_slot_next;
                            base_next  = 1'b1;
                            state_next = fcct_pkg::ST_BRD;
                        end
                    end
                end
            end
            fcct_pkg::ST_BRD: begin
                state_next = fcct_pkg::ST_BCMP;
            end
            fcct_pkg::ST_BCMP: begin
                if (wb_reg) begin
                    // second walk stores the whole frame of a changed slot
                    byte_we    = 1'b1;
                    i_next     = i_reg + 7'd1;
                    state_next = (i_next == len_reg) ? fcct_pkg::ST_SUM : fcct_pkg::ST_BRD;
                end else if (!(differ && rep_reg < 5'(MAX_REPORTED) && !out_free)) begin
                    if (differ) begin
                        total_next = total_reg + 7'd1;
                        if (rep_reg < 5'(MAX_REPORTED)) begin
                            rep_next             = rep_reg + 5'd1;
                            out_next             = '0;
                            out_next.record_type = fcct_pkg::REC_CHANGE;
                            out_next.byte_index  = i_reg[5:0];
                            out_next.before_value = byte_rd;
                            out_next.after_value = stg_rd;
                            out_next.change_mask = byte_rd ^ stg_rd;
                            m_valid_next         = 1'b1;
                        end
                    end
                    // checksum bytes are kept unless the frame turns out changed
                    byte_we = base_reg || !skip;
                    i_next  = i_reg + 7'd1;
                    if (i_next == len_reg) begin
                        if (!base_reg && total_next != 7'd0) begin
                            wb_next    = 1'b1;
                            i_next     = 7'd0;
                            state_next = fcct_pkg::ST_BRD;
                        end else begin
                            state_next = fcct_pkg::ST_SUM;
                        end
                    end else begin
                        state_next = fcct_pkg::ST_BRD;
                    end
                end
            end
            fcct_pkg::ST_SUM: begin
                if (out_free) begin
                    out_next              = '0;
                    out_next.record_type  = fcct_pkg::REC_SUMMARY;
                    out_next.last_record  = 1'b1;
                    m_valid_next          = 1'b1;
                    if (none_reg) begin
                        out_next.disposition = fcct_pkg::DISP_NONE;
                    end else begin
                        out_next.frame_length = len_reg;
                        out_next.change_total = total_reg;
                        if (base_reg) begin
                            out_next.disposition = fcct_pkg::DISP_BASELINE;
                        end else if (total_reg == 7'd0) begin
                            out_next.disposition = fcct_pkg::DISP_UNCHANGED;
                        end else begin
                            out_next.disposition = fcct_pkg::DISP_CHANGED;
                        end
                        meta_we             = 1'b1;
                        used_next[slot_reg] = 1'b1;
                    end
                    state_next = fcct_pkg::ST_IDLE;
                end
            end
            default: state_next = fcct_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fcct_pkg::ST_IDLE;
            count_reg   <= 7'd0;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
            rep_reg     <= 5'd0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
            rep_reg     <= rep_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg        <= len_next;
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        seq_reg        <= seq_next;
        none_reg       <= none_next;
        cnt_reg        <= cnt_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        old_found_reg  <= old_found_next;
        old_slot_reg   <= old_slot_next;
        old_age_reg    <= old_age_next;
        slot_reg       <= slot_next;
        base_reg       <= base_next;
        wb_reg         <= wb_next;
        i_reg          <= i_next;
        total_reg      <= total_next;
        out_reg        <= out_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = out_reg.last_record;
    assign m_tuser  = {out_reg.disposition, out_reg.record_type};
    assign m_tdata  = {4'd0, out_reg.frame_length, out_reg.change_total,
                       out_reg.change_mask, out_reg.after_value,
                       out_reg.before_value, out_reg.byte_index};

    // a pending change record always has its summary still to come
    a_change_not_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.record_type == fcct_pkg::REC_CHANGE)
            |-> state_reg != fcct_pkg::ST_IDLE)
        else $error("change record pending with block idle");

    a_rep_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_reg <= 5'(MAX_REPORTED))
        else $error("too many change records");

    // leaving the summary state always loads the summary
    a_sum_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fcct_pkg::ST_SUM && state_next == fcct_pkg::ST_IDLE)
            |=> (m_valid_reg && out_reg.last_record))
        else $error("summary not issued");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fcct_pkg::ST_BCMP) |-> !s_acc)
        else $error("request taken during compare");

endmodule

>>> hw/rtl/fcct_ram.sv
// ---------------------------------------------------------------------------
// fcct_ram
// Simple dual-port synchronous ram, one write and one registered read port.
// ---------------------------------------------------------------------------
module fcct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Streams frames into the change capture table, predicts the change records
// and summaries for each frame and checks every record the block issues.
// ---------------------------------------------------------------------------

class change_scoreboard;
    // configuration copy
    logic [5:0] csum_high, csum_low, csum_extra;
    logic [6:0] long_len;
    // staging
    logic [7:0] stage [33];
    int         stage_cnt;
    // slot table
    bit         used [16];
    logic [7:0] kind [16];
    logic [15:0] key [16];
    int         slen [16];
    logic [31:0] age [16];
    logic [7:0] sbytes [16][33];
    fcct_pkg::out_rec_t pending [$];
    int         errors;

    function void clear();
        csum_high = fcct_pkg::CSUM_HIGH_RST; csum_low = fcct_pkg::CSUM_LOW_RST;
        csum_extra = fcct_pkg::CSUM_EXTRA_RST; long_len = fcct_pkg::LONG_LEN_RST;
        stage_cnt = 0;
        errors = 0;
        for (int s = 0; s < 16; s++) begin
            used[s] = 0; kind[s] = 0; key[s] = 0; slen[s] = 0; age[s] = 0;
            for (int i = 0; i < 33; i++) sbytes[s][i] = 0;
        end
    endfunction

    function void set_reg(logic [1:0] idx, logic [6:0] val);
        case (idx)
            fcct_pkg::CFG_CSUM_HIGH:  csum_high = val[5:0];
            fcct_pkg::CFG_CSUM_LOW:   csum_low = val[5:0];
            fcct_pkg::CFG_CSUM_EXTRA: csum_extra = val[5:0];
            fcct_pkg::CFG_LONG_LEN:   long_len = val;
            default: ;
        endcase
    endfunction

    function void add_summary(logic [1:0] disp, int total, int len);
        fcct_pkg::out_rec_t r;
        r = '0;
        r.record_type = fcct_pkg::REC_SUMMARY;
        r.disposition = disp;
        r.change_total = total[6:0];
        r.frame_length = len[6:0];
        r.last_record = 1'b1;
        pending.push_back(r);
    endfunction

    function void note_request(logic [7:0] b, bit last, bit valid, logic [7:0] k,
                               logic [15:0] opk, logic [31:0] seq);
        int len, s, fr, od, total, rep;
        fcct_pkg::out_rec_t r;
        if (stage_cnt < 33) begin
            stage[stage_cnt] = b;
            stage_cnt++;
        end else stage_cnt = 34;
        if (!last) return;
        len = stage_cnt;
        stage_cnt = 0;
        if (!valid || len > 33) begin
            add_summary(fcct_pkg::DISP_NONE, 0, 0);
            return;
        end
        s = -1; fr = -1; od = -1;
        for (int i = 0; i < 16; i++) begin
            if (s < 0 && used[i] && kind[i] == k && key[i] == opk) s = i;
            if (!used[i] && fr < 0) fr = i;
            if (used[i] && (od < 0 || age[i] < age[od])) od = i;
        end
        if (s < 0) begin
            s = (fr >= 0) ? fr : od;
            used[s] = 1; kind[s] = k; key[s] = opk; slen[s] = 0; age[s] = 0;
            for (int i = 0; i < 33; i++) sbytes[s][i] = 0;
        end
        if (slen[s] == 0 || slen[s] != len) begin
            store(s, len, seq);
            add_summary(fcct_pkg::DISP_BASELINE, 0, len);
            return;
        end
        total = 0; rep = 0;
        for (int i = 0; i < len; i++) begin
            if (i == csum_high || i == csum_low || (len == long_len && i == csum_extra))
                continue;
            if (sbytes[s][i] == stage[i]) continue;
            total++;
            if (rep < 16) begin
                r = '0;
                r.record_type = fcct_pkg::REC_CHANGE;
                r.byte_index = i[5:0];
                r.before_value = sbytes[s][i];
                r.after_value = stage[i];
                r.change_mask = sbytes[s][i] ^ stage[i];
                pending.push_back(r);
                rep++;
            end
        end
        age[s] = seq;
        if (total == 0) add_summary(fcct_pkg::DISP_UNCHANGED, 0, len);
        else begin
            store(s, len, seq);
            add_summary(fcct_pkg::DISP_CHANGED, total, len);
        end
    endfunction

    function void store(int s, int len, logic [31:0] seq);
        for (int i = 0; i < 33; i++) sbytes[s][i] = (i < len) ? stage[i] : 8'd0;
        slen[s] = len;
        age[s] = seq;
    endfunction

    function void report(string what);
        $display("mismatch at %0t: %s", $time, what);
        errors++;
    endfunction

    function void check_record(fcct_pkg::out_rec_t got);
        fcct_pkg::out_rec_t w;
        if (pending.size() == 0) begin
            report($sformatf("unexpected record %h", got));
            return;
        end
        w = pending.pop_front();
        if (got.record_type != w.record_type) report("record_type");
        if (got.byte_index != w.byte_index) report("byte_index");
        if (got.before_value != w.before_value) report("before_value");
        if (got.after_value != w.after_value) report("after_value");
        if (got.change_mask != w.change_mask) report("change_mask");
        if (got.disposition != w.disposition) report("disposition");
        if (got.change_total != w.change_total) report("change_total");
        if (got.frame_length != w.frame_length) report("frame_length");
        if (got.last_record != w.last_record) report("last_record");
    endfunction
endclass

module tb_top;
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready, s_tlast;
    logic [55:0] s_tdata;
    logic [8:0]  s_tuser;
    logic        m_tvalid, m_tready, m_tlast;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_wdata;

    change_scoreboard sb;
    int  hold_off;     // cycles of a long receiver stall still to run
    bit  stall_on;

    frame_change_capture_table_core u_dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: own stall pattern plus long hold-offs
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else if (stall_on) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= 1'b1;
    end

    always @(posedge aclk) begin
        fcct_pkg::out_rec_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.record_type = m_tuser[0];
            got.disposition = m_tuser[2:1];
            got.byte_index = m_tdata[5:0];
            got.before_value = m_tdata[13:6];
            got.after_value = m_tdata[21:14];
            got.change_mask = m_tdata[29:22];
            got.change_total = m_tdata[36:30];
            got.frame_length = m_tdata[43:37];
            got.last_record = m_tlast;
            sb.check_record(got);
        end
    end

    task automatic send_byte(logic [7:0] b, bit last, bit valid, logic [7:0] k,
                             logic [15:0] opk, logic [31:0] seq);
        s_tvalid <= 1'b1;
        s_tdata <= {seq, opk, b};
        s_tlast <= last;
        s_tuser <= {k, valid};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(b, last, valid, k, opk, seq);
        @(negedge aclk);
        // random gap between bursts
        if ($urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
    endtask

    // one frame; bytes follow a template from base, nflip is the percent chance of a random byte
    task automatic send_frame(int len, bit valid, logic [7:0] k, logic [15:0] opk,
                              logic [31:0] seq, int nflip, logic [7:0] base);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = base + 8'(i * 37);
            if (nflip > 0 && $urandom_range(0, 99) < nflip) b = 8'($urandom);
            send_byte(b, i == len - 1, valid, k, opk, seq);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    initial begin
        int items;
        sb = new();
        sb.clear();
        aresetn = 0; s_tvalid = 0; s_tdata = '0; s_tlast = 0; s_tuser = '0;
        m_tready = 0; cfg_wr_en = 0; cfg_index = fcct_pkg::CFG_CSUM_HIGH; cfg_wdata = '0;
        hold_off = 0; stall_on = 0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: baseline, unchanged, changed, invalid, too long, extremes
        send_frame(1, 1, 8'hff, 16'hffff, 32'hffffffff, 0, 8'h00);
        send_frame(1, 1, 8'hff, 16'hffff, 32'h0, 0, 8'h00);
        send_frame(1, 1, 8'hff, 16'hffff, 32'h1, 0, 8'hff);
        send_frame(33, 1, 8'h00, 16'h0000, 32'h5, 0, 8'h11);
        send_frame(33, 1, 8'h00, 16'h0000, 32'h6, 100, 8'h11);
        send_frame(3, 0, 8'h00, 16'h0000, 32'h7, 0, 8'h22);
        send_frame(36, 1, 8'h01, 16'h0001, 32'h8, 0, 8'h33);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(fcct_pkg::CFG_CSUM_HIGH, 7'd0);
                    write_reg(fcct_pkg::CFG_CSUM_LOW, 7'd63);
                    write_reg(fcct_pkg::CFG_CSUM_EXTRA, 7'd5);
                    write_reg(fcct_pkg::CFG_LONG_LEN, 7'd8);
                end
                1: begin
                    write_reg(fcct_pkg::CFG_CSUM_HIGH, 7'h7f);
                    write_reg(fcct_pkg::CFG_CSUM_LOW, 7'd1);
                    write_reg(fcct_pkg::CFG_CSUM_EXTRA, 7'd0);
                    write_reg(fcct_pkg::CFG_LONG_LEN, 7'd64);
                end
                2: begin
                    write_reg(fcct_pkg::CFG_CSUM_HIGH, 7'd2);
                    write_reg(fcct_pkg::CFG_CSUM_LOW, 7'd3);
                    write_reg(fcct_pkg::CFG_CSUM_EXTRA, 7'd4);
                    write_reg(fcct_pkg::CFG_LONG_LEN, 7'd1);
                end
                default: begin
                    write_reg(fcct_pkg::CFG_CSUM_HIGH, 7'd18);
                    write_reg(fcct_pkg::CFG_CSUM_LOW, 7'd19);
                    write_reg(fcct_pkg::CFG_CSUM_EXTRA, 7'd32);
                    write_reg(fcct_pkg::CFG_LONG_LEN, 7'd33);
                end
            endcase
            stall_on = (ph != 2);
            if (ph == 1) hold_off = 400;
            items = 0;
            while (items < 65) begin
                int len, sel;
                logic [7:0] k;
                logic [15:0] opk;
                sel = $urandom_range(0, 19);
                len = (sel == 0) ? $urandom_range(34, 38) :
                      (sel < 3) ? 33 : $urandom_range(1, 10);
                // few keys so slots are revisited; wide keys force eviction
                k = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
                opk = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, 5));
                send_frame(len, $urandom_range(0, 15) != 0, k, opk, $urandom,
                           $urandom_range(0, 2) * 30, 8'(k ^ opk[7:0]));
                items += len;
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/fcct_pkg.sv
hw/rtl/fcct_ram.sv
hw/rtl/frame_change_capture_table_core.sv
dv/tb_top.sv
